// File: rtl/core/hpid_pkg.sv
// Shared types and constants for the heater PID controller with feedforward.
`default_nettype none

package hpid_pkg;

    localparam int HPID_HISTORY_DEPTH = 8;
    localparam int LOOP_HZ            = 5;
    localparam int DUTY_MAX           = 100;
    localparam int GAIN_SCALE         = 4096;
    localparam int DEN_BASE           = GAIN_SCALE * LOOP_HZ;

    localparam int TEMP_W     = 16;
    localparam int GAIN_W     = 16;
    localparam int ERR_W      = TEMP_W + 1;
    localparam int INTEG_W    = 24;
    localparam int LIMIT_W    = 23;
    localparam int DUTY_W     = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_TEMP = 3'd0,
        CFG_PROP_GAIN   = 3'd1,
        CFG_INTEG_GAIN  = 3'd2,
        CFG_DERIV_GAIN  = 3'd3,
        CFG_FWD_GAIN    = 3'd4,
        CFG_FWD_BIAS    = 3'd5,
        CFG_INTEG_LIMIT = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ERR,
        S_INT,
        S_MUL,
        S_CHK,
        S_DIV,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// File: rtl/core/hpid_hist.sv
// Temperature history ring with write pointer, valid bits and registered read.
`default_nettype none

module hpid_hist
    import hpid_pkg::*;
#(
    parameter int DEPTH = HPID_HISTORY_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [TEMP_W-1:0] i_data,
    output logic      [TEMP_W-1:0] o_old
);

    localparam int PW = $clog2(DEPTH);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    logic [TEMP_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]  r_vld;
    logic [PW-1:0]     r_pos;
    logic [TEMP_W-1:0] r_rd_data;
    logic              r_rd_vld;
    logic [PW-1:0]     w_next;

    assign w_next = (r_pos == LAST) ? '0 : r_pos + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else if (i_push) begin
            r_pos        <= w_next;
            r_vld[r_pos] <= 1'b1;
            r_rd_vld     <= r_vld[w_next];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_pos] <= i_data;
            r_rd_data    <= r_mem[w_next];
        end
    end

    // An entry never written reads as zero, which means no history.
    assign o_old = r_rd_vld ? r_rd_data : '0;

endmodule

`default_nettype wire

// File: rtl/core/heater_pid_with_feedforward.sv
// A failed read is accepted and completes with no result; a zero setpoint goes
// straight to the result state, and a normal sample passes the error, integrator,
// multiply, check and divide states (no divide when the sum is not positive or
// saturates at full duty). The four terms share one multiplier, and a new sample
// is taken only in the idle state, after the last result is loaded; a stalled result delays the next.
// Reset clears configuration, integrator, history and all control state.
`default_nettype none

module heater_pid_with_feedforward
    import hpid_pkg::*;
#(
    parameter int HISTORY_DEPTH = HPID_HISTORY_DEPTH
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic         [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic         [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic signed  [TEMP_W-1:0]    i_temperature,
    input  wire logic                         i_reading_ok,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic              [DUTY_W-1:0]    o_duty_percent,
    output logic                              o_disabled
);

    localparam int SPAN    = HISTORY_DEPTH - 1;
    localparam int SPAN_W  = $clog2(HISTORY_DEPTH);
    localparam int OP_W    = INTEG_W + 1 + SPAN_W;
    localparam int PROD_W  = OP_W + GAIN_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int GAIN_SH = $clog2(GAIN_SCALE);
    localparam int QDIV    = LOOP_HZ * SPAN;
    localparam int QX_W    = $clog2(DUTY_MAX * QDIV);
    localparam int QSH     = QX_W + $clog2(QDIV);
    localparam int QP_W    = 2 * QX_W + 1;

    localparam logic signed [OP_W-1:0]  K_PF  = OP_W'(LOOP_HZ * SPAN);
    localparam logic signed [OP_W-1:0]  K_I   = OP_W'(SPAN);
    localparam logic signed [OP_W-1:0]  K_D   = OP_W'(LOOP_HZ * LOOP_HZ);
    localparam logic signed [SUM_W-1:0] FULL  = SUM_W'(DUTY_MAX * DEN_BASE * SPAN);
    localparam logic [DUTY_W-1:0]       DMAX  = DUTY_W'(DUTY_MAX);
    localparam logic [QX_W:0]           QMUL  =
        (QX_W+1)'(((longint'(1) <<< QSH) + QDIV - 1) / QDIV);

    t_state r_state;
    t_state n_state;

    logic signed [TEMP_W-1:0]  r_target;
    logic signed [GAIN_W-1:0]  r_prop_gain;
    logic signed [GAIN_W-1:0]  r_integ_gain;
    logic signed [GAIN_W-1:0]  r_deriv_gain;
    logic signed [GAIN_W-1:0]  r_fwd_gain;
    logic signed [TEMP_W-1:0]  r_fwd_bias;
    logic        [LIMIT_W-1:0] r_integ_limit;

    logic signed [INTEG_W-1:0] r_integ;
    logic signed [TEMP_W-1:0]  r_temp;
    logic signed [ERR_W-1:0]   r_err;
    logic signed [ERR_W-1:0]   r_ffd;
    logic signed [ERR_W-1:0]   r_dtemp;
    logic [2:0]                r_step;

    logic signed [OP_W-1:0]    r_op_a;
    logic signed [GAIN_W-1:0]  r_op_b;
    logic                      r_opv;
    logic signed [PROD_W-1:0]  r_prod;
    logic                      r_prodv;
    logic signed [SUM_W-1:0]   r_sum;

    logic [DUTY_W-1:0]         r_res_duty;
    logic                      r_res_dis;
    logic                      r_out_valid;
    logic [DUTY_W-1:0]         r_out_duty;
    logic                      r_out_dis;

    logic                      w_accept;
    logic                      w_hist_push;
    logic                      w_issue;
    logic                      w_out_load;
    logic [TEMP_W-1:0]         w_old;
    logic signed [ERR_W-1:0]   w_old_s;
    logic signed [INTEG_W:0]   w_acc_raw;
    logic signed [INTEG_W:0]   w_lim;
    logic signed [INTEG_W:0]   w_acc;
    logic signed [OP_W-1:0]    w_op_a;
    logic signed [GAIN_W-1:0]  w_op_b;
    logic                      w_sum_pos;
    logic [QX_W-1:0]           w_qx;
    logic [QP_W-1:0]           w_qprod;

    hpid_hist #(
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_hist_push),
        .i_data  (r_temp),
        .o_old   (w_old)
    );

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target      <= '0;
            r_prop_gain   <= '0;
            r_integ_gain  <= '0;
            r_deriv_gain  <= '0;
            r_fwd_gain    <= '0;
            r_fwd_bias    <= '0;
            r_integ_limit <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TARGET_TEMP: r_target      <= i_cfg_data[TEMP_W-1:0];
                CFG_PROP_GAIN:   r_prop_gain   <= i_cfg_data[GAIN_W-1:0];
                CFG_INTEG_GAIN:  r_integ_gain  <= i_cfg_data[GAIN_W-1:0];
                CFG_DERIV_GAIN:  r_deriv_gain  <= i_cfg_data[GAIN_W-1:0];
                CFG_FWD_GAIN:    r_fwd_gain    <= i_cfg_data[GAIN_W-1:0];
                CFG_FWD_BIAS:    r_fwd_bias    <= i_cfg_data[TEMP_W-1:0];
                CFG_INTEG_LIMIT: r_integ_limit <= i_cfg_data[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_sum_pos = !r_sum[SUM_W-1] && (r_sum != '0);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_reading_ok) begin
                    n_state = (r_target == '0) ? S_DONE : S_ERR;
                end
            end
            S_ERR: n_state = S_INT;
            S_INT: n_state = S_MUL;
            S_MUL: begin
                if (r_step == 3'd5) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (w_sum_pos && r_sum < FULL) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DIV: n_state = S_DONE;
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        w_hist_push = 1'b0;
        w_issue     = 1'b0;
        w_out_load  = 1'b0;
        unique case (r_state)
            S_IDLE: o_in_ready  = 1'b1;
            S_ERR:  w_hist_push = 1'b1;
            S_MUL:  w_issue     = ~r_step[2];
            S_DONE: w_out_load  = ~r_out_valid | i_out_ready;
            default: begin
            end
        endcase
    end

    assign w_accept = i_in_valid & o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign w_old_s   = ERR_W'($signed(w_old));
    assign w_acc_raw = (INTEG_W+1)'(r_integ) + (INTEG_W+1)'(r_err);
    assign w_lim     = $signed({2'b00, r_integ_limit});

    always_comb begin
        if (w_acc_raw < -w_lim) begin
            w_acc = -w_lim;
        end else if (w_acc_raw > w_lim) begin
            w_acc = w_lim;
        end else begin
            w_acc = w_acc_raw;
        end
    end

    // Operands are scaled by constants so that every term sits over one denominator.
    always_comb begin
        unique case (r_step[1:0])
            2'd0: begin
                w_op_a = OP_W'(r_err) * K_PF;
                w_op_b = r_prop_gain;
            end
            2'd1: begin
                w_op_a = OP_W'(r_ffd) * K_PF;
                w_op_b = r_fwd_gain;
            end
            2'd2: begin
                w_op_a = OP_W'(r_integ) * K_I;
                w_op_b = r_integ_gain;
            end
            2'd3: begin
                w_op_a = OP_W'(r_dtemp) * K_D;
                w_op_b = r_deriv_gain;
            end
            default: begin
                w_op_a = '0;
                w_op_b = '0;
            end
        endcase
    end

    // The gain scale is a power of two and is shifted out first; the rest of the
    // denominator is removed by multiplying with its rounded-up reciprocal.
    assign w_qx    = r_sum[GAIN_SH +: QX_W];
    assign w_qprod = QP_W'(w_qx) * QP_W'(QMUL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_step  <= '0;
            r_opv   <= 1'b0;
            r_prodv <= 1'b0;
        end else begin
            r_opv   <= w_issue;
            r_prodv <= r_opv;
            unique case (r_state)
                S_INT:   begin
                    r_integ <= w_acc[INTEG_W-1:0];
                    r_step  <= '0;
                end
                S_MUL:   r_step <= r_step + 3'd1;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_temp     <= i_temperature;
            r_res_duty <= '0;
            r_res_dis  <= 1'b1;
        end
        if (r_state == S_ERR) begin
            r_err <= ERR_W'(r_target) - ERR_W'(r_temp);
            r_ffd <= ERR_W'(r_target) - ERR_W'(r_fwd_bias);
        end
        if (r_state == S_INT) begin
            r_dtemp <= (w_old == '0) ? '0 : ERR_W'(r_temp) - w_old_s;
            r_sum   <= '0;
        end
        if (w_issue) begin
            r_op_a <= w_op_a;
            r_op_b <= w_op_b;
        end
        if (r_opv) begin
            r_prod <= r_op_a * r_op_b;
        end
        if (r_prodv) begin
            r_sum <= r_sum + SUM_W'(r_prod);
        end
        if (r_state == S_CHK) begin
            r_res_dis  <= 1'b0;
            r_res_duty <= w_sum_pos ? DMAX : '0;
        end
        if (r_state == S_DIV) begin
            r_res_duty <= w_qprod[QSH +: DUTY_W];
        end
        if (w_out_load) begin
            r_out_duty <= r_res_duty;
            r_out_dis  <= r_res_dis;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_duty_percent = r_out_duty;
    assign o_disabled     = r_out_dis;

`ifndef SYNTHESIS
    a_integ_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL && r_step == 3'd0) |->
        ((INTEG_W+1)'(r_integ) <= w_lim && (INTEG_W+1)'(r_integ) >= -w_lim))
        else $error("integrator outside its clamp after update");

    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_duty_percent <= DMAX && (!o_disabled || o_duty_percent == '0)))
        else $error("result duty out of range or disabled with nonzero duty");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> (o_out_valid && r_state == S_IDLE))
        else $error("finished result not presented");

    a_mul_in_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prodv |-> (r_state == S_MUL))
        else $error("multiplier result outside the multiply pass");
`endif

endmodule

`default_nettype wire

// File: tb/heater_duty_checker.sv
// Checker that predicts and compares heater duty results from the observed channels.
module heater_duty_checker
    import hpid_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    input  logic                         i_cfg_ready,
    input  logic        [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic        [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic signed [TEMP_W-1:0]     i_temperature,
    input  logic                         i_reading_ok,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic        [DUTY_W-1:0]     i_duty_percent,
    input  logic                         i_disabled,
    output int                           o_pending,
    output int                           o_fail_count
);

    localparam longint SPAN     = HPID_HISTORY_DEPTH - 1;
    localparam longint DUTY_DEN = longint'(DEN_BASE) * SPAN;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              disabled;
    } t_duty_result;

    t_duty_result duty_expected_q[$];
    int           fail_count = 0;

    logic signed [TEMP_W-1:0]  target_temp;
    logic signed [GAIN_W-1:0]  prop_gain;
    logic signed [GAIN_W-1:0]  integ_gain;
    logic signed [GAIN_W-1:0]  deriv_gain;
    logic signed [GAIN_W-1:0]  fwd_gain;
    logic signed [TEMP_W-1:0]  fwd_bias;
    logic        [LIMIT_W-1:0] integ_limit;
    logic signed [INTEG_W-1:0] integ_acc;
    logic signed [TEMP_W-1:0]  temp_ring [HPID_HISTORY_DEPTH];
    int unsigned               ring_pos;

    function automatic void predict_tick(input logic signed [TEMP_W-1:0] temp,
                                         input logic ok);
        longint                   err;
        longint                   acc;
        longint                   dtemp;
        longint                   sum;
        longint                   q;
        logic signed [TEMP_W-1:0] old;
        t_duty_result             r;
        if (!ok) begin
            return;
        end
        if (target_temp == 0) begin
            r.duty     = '0;
            r.disabled = 1'b1;
            duty_expected_q.push_back(r);
            return;
        end
        err = longint'(target_temp) - longint'(temp);
        acc = longint'(integ_acc) + err;
        if (acc < -longint'(integ_limit)) begin
            acc = -longint'(integ_limit);
        end else if (acc > longint'(integ_limit)) begin
            acc = longint'(integ_limit);
        end
        integ_acc = INTEG_W'(acc);
        temp_ring[ring_pos] = temp;
        ring_pos = (ring_pos == HPID_HISTORY_DEPTH - 1) ? 0 : ring_pos + 1;
        old = temp_ring[ring_pos];
        // A stored zero marks an empty history slot, so the derivative is zero.
        if (old == 0) begin
            old = temp;
        end
        dtemp = longint'(temp) - longint'(old);
        sum = err * longint'(prop_gain) * LOOP_HZ * SPAN
            + acc * longint'(integ_gain) * SPAN
            + dtemp * longint'(deriv_gain) * LOOP_HZ * LOOP_HZ
            + (longint'(target_temp) - longint'(fwd_bias)) * longint'(fwd_gain)
              * LOOP_HZ * SPAN;
        if (sum <= 0) begin
            r.duty = '0;
        end else begin
            q = sum / DUTY_DEN;
            r.duty = (q > DUTY_MAX) ? DUTY_W'(DUTY_MAX) : DUTY_W'(q);
        end
        r.disabled = 1'b0;
        duty_expected_q.push_back(r);
    endfunction

    always @(posedge i_clk) begin
        t_duty_result got;
        t_duty_result want;
        if (!i_rst_n) begin
            target_temp = '0;
            prop_gain   = '0;
            integ_gain  = '0;
            deriv_gain  = '0;
            fwd_gain    = '0;
            fwd_bias    = '0;
            integ_limit = '0;
            integ_acc   = '0;
            ring_pos    = 0;
            for (int k = 0; k < HPID_HISTORY_DEPTH; k++) begin
                temp_ring[k] = '0;
            end
            duty_expected_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got.duty     = i_duty_percent;
                got.disabled = i_disabled;
                if (duty_expected_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("Unexpected result: duty %0d disabled %0b",
                                 got.duty, got.disabled);
                    end
                end else begin
                    want = duty_expected_q.pop_front();
                    if (got.duty !== want.duty || got.disabled !== want.disabled) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("Mismatch: expected duty %0d disabled %0b, got duty %0d disabled %0b",
                                     want.duty, want.disabled, got.duty, got.disabled);
                        end
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TARGET_TEMP: target_temp = i_cfg_data[TEMP_W-1:0];
                    CFG_PROP_GAIN:   prop_gain   = i_cfg_data[GAIN_W-1:0];
                    CFG_INTEG_GAIN:  integ_gain  = i_cfg_data[GAIN_W-1:0];
                    CFG_DERIV_GAIN:  deriv_gain  = i_cfg_data[GAIN_W-1:0];
                    CFG_FWD_GAIN:    fwd_gain    = i_cfg_data[GAIN_W-1:0];
                    CFG_FWD_BIAS:    fwd_bias    = i_cfg_data[TEMP_W-1:0];
                    CFG_INTEG_LIMIT: integ_limit = i_cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                predict_tick(i_temperature, i_reading_ok);
            end
        end
        o_pending    <= duty_expected_q.size();
        o_fail_count <= fail_count;
    end

endmodule

// File: tb/heater_pid_with_feedforward_tb.sv
// Testbench top that drives samples and register writes into the heater PID block.
module heater_pid_with_feedforward_tb
    import hpid_pkg::*;
;

    localparam int                   CYCLE_LIMIT     = 500000;
    localparam int                   SETTLE_CYCLES   = 24;
    localparam int                   HOLD_CYCLES     = 400;
    localparam int                   PHASES          = 22;
    localparam int                   ITEMS_PER_PHASE = 50;
    localparam int                   PRESSURE_PHASE  = 9;
    localparam int                   QUIET_PHASE     = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX  = 3'd7;

    logic                         clk            = 1'b0;
    logic                         rst_n          = 1'b0;
    logic                         cfg_valid      = 1'b0;
    logic        [CFG_IDX_W-1:0]  cfg_index      = '0;
    logic        [CFG_DATA_W-1:0] cfg_data       = '0;
    logic                         in_valid       = 1'b0;
    logic signed [TEMP_W-1:0]     in_temperature = '0;
    logic                         in_reading_ok  = 1'b0;
    logic                         out_ready      = 1'b0;
    logic                         cfg_ready;
    logic                         in_ready;
    logic                         out_valid;
    logic        [DUTY_W-1:0]     duty_percent;
    logic                         disabled;
    int                           pending;
    int                           fail_count;

    logic                         idle_on        = 1'b1;
    logic                         pressure_on    = 1'b0;
    logic                         pressure_done  = 1'b0;
    logic signed [TEMP_W-1:0]     setpoint       = '0;
    int                           cycle_count    = 0;

    heater_pid_with_feedforward u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_temperature  (in_temperature),
        .i_reading_ok   (in_reading_ok),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_duty_percent (duty_percent),
        .o_disabled     (disabled)
    );

    heater_duty_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_temperature  (in_temperature),
        .i_reading_ok   (in_reading_ok),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_duty_percent (duty_percent),
        .i_disabled     (disabled),
        .o_pending      (pending),
        .o_fail_count   (fail_count)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        logic [CFG_DATA_W-1:0] word;
        word = data;
        if (idx != CFG_INTEG_LIMIT) begin
            word[CFG_DATA_W-1:TEMP_W] = (CFG_DATA_W-TEMP_W)'($urandom);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic put_sample(input logic signed [TEMP_W-1:0] temp, input logic ok);
        int unsigned gap;
        if (idle_on && !pressure_on && $urandom_range(99) < 33) begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        in_temperature <= temp;
        in_reading_ok  <= ok;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [GAIN_W-1:0] rand_gain();
        if ($urandom_range(7) == 0) begin
            return GAIN_W'($urandom);
        end
        return GAIN_W'(int'($urandom_range(1536)) - 256);
    endfunction

    function automatic logic signed [TEMP_W-1:0] pick_temp(input logic signed [TEMP_W-1:0] center);
        int t;
        case ($urandom_range(19))
            0:       t = 0;
            1:       t = -32768;
            2:       t = 32767;
            3, 4:    t = $signed(TEMP_W'($urandom));
            default: t = int'(center) + int'($urandom_range(960)) - 480;
        endcase
        if (t > 32767) begin
            t = 32767;
        end else if (t < -32768) begin
            t = -32768;
        end
        return TEMP_W'(t);
    endfunction

    task automatic program_phase(input int flavor);
        logic signed [GAIN_W-1:0] kp;
        logic signed [GAIN_W-1:0] ki;
        logic signed [GAIN_W-1:0] kd;
        logic signed [GAIN_W-1:0] ff;
        logic signed [TEMP_W-1:0] ffo;
        logic [LIMIT_W-1:0]       limit;
        case (flavor)
            0: begin
                setpoint = 16'sh7FFF;
                kp = 16'sh7FFF; ki = 16'sh7FFF; kd = 16'sh7FFF; ff = 16'sh7FFF;
                ffo = 16'sh7FFF;
                limit = '1;
            end
            1: begin
                setpoint = 16'sh8000;
                kp = 16'sh8000; ki = 16'sh8000; kd = 16'sh8000; ff = 16'sh8000;
                ffo = 16'sh8000;
                limit = '0;
            end
            default: begin
                case ($urandom_range(5))
                    0:       setpoint = '0;
                    1:       setpoint = TEMP_W'($urandom);
                    default: setpoint = TEMP_W'($urandom_range(320, 4000));
                endcase
                kp = rand_gain();
                ki = rand_gain();
                kd = rand_gain();
                ff = rand_gain();
                ffo = ($urandom_range(3) == 0) ? TEMP_W'($urandom)
                                               : TEMP_W'(int'($urandom_range(3200)) - 1600);
                limit = ($urandom_range(4) == 0) ? LIMIT_W'($urandom)
                                                 : LIMIT_W'($urandom_range(40000));
            end
        endcase
        write_reg(CFG_TARGET_TEMP, CFG_DATA_W'(setpoint));
        write_reg(CFG_PROP_GAIN,   CFG_DATA_W'(kp));
        write_reg(CFG_INTEG_GAIN,  CFG_DATA_W'(ki));
        write_reg(CFG_DERIV_GAIN,  CFG_DATA_W'(kd));
        write_reg(CFG_FWD_GAIN,    CFG_DATA_W'(ff));
        write_reg(CFG_FWD_BIAS,    CFG_DATA_W'(ffo));
        write_reg(CFG_INTEG_LIMIT, CFG_DATA_W'(limit));
        if ($urandom_range(3) == 0) begin
            write_reg(CFG_UNUSED_IDX, CFG_DATA_W'($urandom));
        end
    endtask

    initial begin
        forever begin
            @(posedge clk);
            // The receiver holds off once for a long stretch so that the block backs up.
            if (pressure_on && !pressure_done) begin
                pressure_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_ready <= !idle_on || ($urandom_range(99) >= 33);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // With every register at reset the setpoint is zero, so the heater is off.
        put_sample(16'sd320, 1'b1);
        put_sample(-16'sd1, 1'b0);
        settle();

        write_reg(CFG_TARGET_TEMP, 23'd1600);
        write_reg(CFG_PROP_GAIN,   23'd256);
        write_reg(CFG_INTEG_GAIN,  23'd128);
        write_reg(CFG_DERIV_GAIN,  23'd1024);
        write_reg(CFG_FWD_GAIN,    23'd64);
        write_reg(CFG_FWD_BIAS,    23'd320);
        write_reg(CFG_INTEG_LIMIT, 23'd2000);
        write_reg(CFG_UNUSED_IDX,  23'h5A5A5);
        setpoint = 16'sd1600;
        put_sample(16'sd0, 1'b1);
        put_sample(16'sh7FFF, 1'b1);
        put_sample(16'sh8000, 1'b1);
        for (int k = 0; k < 7; k++) begin
            put_sample(TEMP_W'(1500 + 20 * k), 1'b1);
        end
        put_sample(16'sd1234, 1'b0);
        settle();

        // Wind the integrator far up, then lower the limit below it.
        write_reg(CFG_INTEG_LIMIT, 23'h7FFFFF);
        repeat (3) put_sample(16'sh8000, 1'b1);
        settle();
        write_reg(CFG_INTEG_LIMIT, 23'd50);
        put_sample(16'sd1600, 1'b1);
        settle();

        write_reg(CFG_TARGET_TEMP, 23'h8000);
        write_reg(CFG_PROP_GAIN,   23'h8000);
        write_reg(CFG_INTEG_GAIN,  23'h7FFF);
        write_reg(CFG_DERIV_GAIN,  23'h8000);
        write_reg(CFG_FWD_GAIN,    23'h7FFF);
        write_reg(CFG_FWD_BIAS,    23'h7FFF);
        write_reg(CFG_INTEG_LIMIT, 23'd0);
        put_sample(16'sh7FFF, 1'b1);
        put_sample(16'sh8000, 1'b1);
        settle();
        write_reg(CFG_TARGET_TEMP, 23'h7FFF);
        write_reg(CFG_PROP_GAIN,   23'h7FFF);
        write_reg(CFG_FWD_GAIN,    23'h8000);
        write_reg(CFG_FWD_BIAS,    23'h8000);
        put_sample(16'sh8000, 1'b1);
        put_sample(16'sh7FFF, 1'b1);
        settle();

        for (int ph = 0; ph < PHASES; ph++) begin
            program_phase(ph);
            idle_on     = (ph != QUIET_PHASE);
            pressure_on = (ph == PRESSURE_PHASE);
            repeat (ITEMS_PER_PHASE) begin
                put_sample(pick_temp(setpoint), $urandom_range(99) < 88);
            end
            settle();
            pressure_on = 1'b0;
        end

        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
